>>> hdl/dwss_pkg.sv
// types and constants for the delayed work slot scheduler
// used by dwss_front, dwss_back and delayed_work_slot_scheduler_top
package dwss_pkg;

  typedef enum logic [1:0] {
    REQ_SUBMIT = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_FETCH  = 2'd2,
    REQ_BAD    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    req_t        req;
    logic        bad_args;
    logic [15:0] tag;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [31:0] delay;
    logic [31:0] elapsed;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic        wake;
    logic [15:0] tag;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [31:0] next_ticks;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_MIN  = 2'd2,
    BK_DONE = 2'd3
  } bk_state_t;

  localparam logic [31:0] DELAY_FOREVER = 32'hFFFF_FFFF;

endpackage

>>> hdl/delayed_work_slot_scheduler_top.sv
// delayed work slot scheduler, top level
// path from input transaction to m_tvalid: queue hop, update pass, min pass
// dwss_back takes a new transaction only once the last result is taken; both
// passes scan the slot table in dwss_back one slot per cycle
// rst is synchronous, active high; empties the table and the command queue
// depends on dwss_pkg, dwss_front, dwss_back
module delayed_work_slot_scheduler_top #(
  parameter int SLOTS         = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: req_type[1:0], handler_tag[17:2], payload_word[81:18],
  // payload_length[85:82], delay_count[117:86], elapsed_count[149:118]
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: status[1:0], wake[2], fetched_tag[18:3], fetched_payload[82:19],
  // fetched_length[86:83], next_ready_ticks[118:87]
  output logic [119:0] m_tdata
);

  logic           cmd_valid, cmd_ready;
  dwss_pkg::cmd_t cmd;
  dwss_pkg::res_t res;
  logic           res_valid;

  // front classifies and queues transactions
  dwss_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .req_type(s_tdata[1:0]), .handler_tag(s_tdata[17:2]),
    .payload_word(s_tdata[81:18]), .payload_length(s_tdata[85:82]),
    .delay_count(s_tdata[117:86]), .elapsed_count(s_tdata[149:118]),
    .cmd_valid, .cmd_ready, .cmd
  );

  // back end holds the result in its done state until taken
  dwss_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid, .res_ready(m_tready), .res
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {1'b0, res.next_ticks, res.length, res.payload, res.tag,
                     res.wake, res.status};

endmodule

>>> hdl/dwss_front.sv
// front end: checks submit arguments, masks payload, two-entry command queue
// depends on dwss_pkg
module dwss_front #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  input  logic [15:0]      handler_tag,
  input  logic [63:0]      payload_word,
  input  logic [3:0]       payload_length,
  input  logic [31:0]      delay_count,
  input  logic [31:0]      elapsed_count,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output dwss_pkg::cmd_t   cmd
);

  dwss_pkg::cmd_t q [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  dwss_pkg::cmd_t c_in;
  logic [63:0]    mask;
  logic           push, pop;

  always_comb begin
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(payload_length)) mask[b*8 +: 8] = 8'hFF;
    end
    c_in.req      = dwss_pkg::req_t'(req_type);
    c_in.bad_args = (handler_tag == 16'd0) || (delay_count == dwss_pkg::DELAY_FOREVER) ||
                    (payload_length > 4'(PAYLOAD_BYTES));
    c_in.tag      = handler_tag;
    c_in.payload  = payload_word & mask;
    c_in.length   = payload_length;
    c_in.delay    = delay_count;
    c_in.elapsed  = elapsed_count;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hdl/dwss_back.sv
// back end: slot table with a one-slot-per-cycle scan sequencer
// depends on dwss_pkg
module dwss_back #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dwss_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output dwss_pkg::res_t res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic        used  [SLOTS];
  logic        ready [SLOTS];
  logic [15:0] tagm  [SLOTS];
  logic [31:0] dly   [SLOTS];
  logic [3:0]  lenm  [SLOTS];
  logic [63:0] paym  [SLOTS];

  dwss_pkg::bk_state_t state, state_next;
  dwss_pkg::cmd_t      cur;
  logic [CW-1:0]       idx;
  logic [IW-1:0]       si;
  logic                done_act;
  logic [31:0]         best;
  logic                any_ready;
  dwss_pkg::res_t      r;
  dwss_pkg::res_t      r_init;

  assign si        = idx[IW-1:0];
  assign cmd_ready = (state == dwss_pkg::BK_IDLE);
  assign res_valid = (state == dwss_pkg::BK_DONE);
  assign res       = r;

  // cleared result with the status that holds if the scan changes nothing
  always_comb begin
    r_init = '0;
    case (cmd.req)
      dwss_pkg::REQ_SUBMIT: r_init.status = cmd.bad_args ? dwss_pkg::ST_INVALID
                                                         : dwss_pkg::ST_FULL;
      dwss_pkg::REQ_FETCH:  r_init.status = dwss_pkg::ST_NONE;
      dwss_pkg::REQ_BAD:    r_init.status = dwss_pkg::ST_INVALID;
      default:              r_init.status = dwss_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dwss_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dwss_pkg::BK_IDLE: if (cmd_valid) state_next = dwss_pkg::BK_SCAN;
      dwss_pkg::BK_SCAN: if (idx == CW'(SLOTS - 1)) state_next = dwss_pkg::BK_MIN;
      dwss_pkg::BK_MIN:  if (idx == CW'(SLOTS - 1)) state_next = dwss_pkg::BK_DONE;
      dwss_pkg::BK_DONE: if (res_ready) state_next = dwss_pkg::BK_IDLE;
      default:           state_next = dwss_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        used[s]  <= 1'b0;
        ready[s] <= 1'b0;
        tagm[s]  <= '0;
        dly[s]   <= '0;
        lenm[s]  <= '0;
      end
      idx <= '0;
    end else begin
      unique case (state)
        dwss_pkg::BK_IDLE: begin
          idx <= '0;
          if (cmd_valid) begin
            cur         <= cmd;
            done_act    <= 1'b0;
            r           <= r_init;
            best        <= dwss_pkg::DELAY_FOREVER;
            any_ready   <= 1'b0;
          end
        end
        dwss_pkg::BK_SCAN: begin
          idx <= (idx == CW'(SLOTS - 1)) ? '0 : idx + CW'(1);
          case (cur.req)
            dwss_pkg::REQ_SUBMIT: begin
              if (!cur.bad_args && !done_act && !used[si]) begin
                used[si]  <= 1'b1;
                tagm[si]  <= cur.tag;
                dly[si]   <= cur.delay;
                lenm[si]  <= cur.length;
                ready[si] <= (cur.delay == 32'd0);
                paym[si]  <= cur.payload;
                r.wake    <= (cur.delay == 32'd0);
                r.status  <= dwss_pkg::ST_OK;
                done_act  <= 1'b1;
              end
            end
            dwss_pkg::REQ_TICK: begin
              if (cur.elapsed != 32'd0 && used[si] && !ready[si]) begin
                if (dly[si] > cur.elapsed) dly[si] <= dly[si] - cur.elapsed;
                else begin
                  dly[si]   <= '0;
                  ready[si] <= 1'b1;
                  r.wake    <= 1'b1;
                end
              end
            end
            dwss_pkg::REQ_FETCH: begin
              if (!done_act && used[si] && ready[si]) begin
                r.tag     <= tagm[si];
                r.length  <= lenm[si];
                r.payload <= paym[si];
                r.status  <= dwss_pkg::ST_OK;
                used[si]  <= 1'b0;
                ready[si] <= 1'b0;
                tagm[si]  <= '0;
                dly[si]   <= '0;
                lenm[si]  <= '0;
                done_act  <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        dwss_pkg::BK_MIN: begin
          idx <= (idx == CW'(SLOTS - 1)) ? '0 : idx + CW'(1);
          if (used[si]) begin
            if (ready[si]) any_ready <= 1'b1;
            else if (dly[si] < best) best <= dly[si];
          end
          if (idx == CW'(SLOTS - 1)) begin
            if (any_ready || (used[si] && ready[si])) r.next_ticks <= '0;
            else if (used[si] && dly[si] < best) r.next_ticks <= dly[si];
            else r.next_ticks <= best;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
